/* rtl/utf8d_pkg.sv */
package utf8d_pkg;

    // Fixed field widths of the byte and code point words.
    localparam int BYTE_W  = 8;
    localparam int CP_W    = 21;
    localparam int WIDTH_W = 3;
    localparam int ERRS_W  = 3;

    // Scalar value limits and the replacement character.
    localparam logic [CP_W-1:0] C_REPL    = 21'h00FFFD;
    localparam logic [CP_W-1:0] C_MAX_CP  = 21'h10FFFF;
    localparam logic [CP_W-1:0] C_SUR_LO  = 21'h00D800;
    localparam logic [CP_W-1:0] C_SUR_HI  = 21'h00DFFF;
    localparam logic [CP_W-1:0] C_MIN_TWO = 21'h000080;
    localparam logic [CP_W-1:0] C_MIN_THR = 21'h000800;
    localparam logic [CP_W-1:0] C_MIN_FOU = 21'h010000;

    // Command for the output side: a run of replacement words followed
    // by at most one trailing word, which is a decoded scalar value.
    typedef struct packed {
        logic [ERRS_W-1:0]  n_err;
        logic               tail_valid;
        logic [CP_W-1:0]    tail_cp;
        logic [WIDTH_W-1:0] tail_width;
        logic               tail_ctl;
    } t_cmd;

endpackage

/* rtl/utf8d_channels.sv */
interface utf8d_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface utf8d_out_if;
    logic        valid;
    logic        ready;
    logic [20:0] code_point;
    logic [2:0]  byte_count;
    logic        is_error;
    logic        is_control;
    logic        last_of_run;

    modport source (output valid, output code_point, output byte_count, output is_error,
                    output is_control, output last_of_run, input ready);
    modport sink   (input valid, input code_point, input byte_count, input is_error,
                    input is_control, input last_of_run, output ready);
endinterface

/* rtl/utf8_stream_decoder_unit.sv */
// Channel   Dir  Payload                                              Word moves when
// i_in      in   text_byte[7:0], end_of_text                          valid & ready
// o_out     out  code_point[20:0], byte_count[2:0], is_error,         valid & ready
//                is_control, last_of_run
//
// One byte word is taken per cycle while the command queue has room. Each byte
// yields zero to four result words, and the output stage sends one per cycle
// while the consumer is ready, so the rate is one byte per cycle until bursts of
// replacements or a stalled consumer fill the queue.
// Reset is synchronous and active low; it closes any open sequence and empties
// the queue and output register. Either side may stall on its own.
module utf8_stream_decoder_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    utf8d_in_if.sink    i_in,
    utf8d_out_if.source o_out
);
    import utf8d_pkg::*;

    // The front decodes each byte against the open sequence and turns it into
    // one command: how many replacement words to send and whether a decoded
    // value follows them. A byte that only opens or extends a sequence gives no command.
    logic w_push;
    t_cmd w_push_cmd;
    logic w_q_full;

    // The back side expands commands into result words.
    logic w_q_valid;
    t_cmd w_q_cmd;
    logic w_pop;

    utf8d_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (w_q_full),
        .o_push   (w_push),
        .o_cmd    (w_push_cmd)
    );

    // A short queue decouples the byte side from the result side, so a
    // stalled consumer does not immediately stop byte intake.
    utf8d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd)
    );

    // The back walks through a command one word per cycle while the consumer is ready
    // and marks the final word of each byte's run.
    utf8d_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .i_cmd   (w_q_cmd),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

`ifndef NO_ASSERTIONS
    // Replacement words always carry U+FFFD, width one and no control flag.
    a_err_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.is_error |->
            o_out.code_point == C_REPL && o_out.byte_count == 3'd1 && !o_out.is_control)
        else $error("replacement word malformed");

    // A decoded single byte word must be ASCII.
    a_one_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.is_error && o_out.byte_count == 3'd1 |->
            o_out.code_point < C_MIN_TWO)
        else $error("single byte word out of ASCII range");

    // Decoded values never exceed the scalar range or fall in the surrogates.
    a_scalar: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.is_error |->
            o_out.code_point <= C_MAX_CP &&
            (o_out.code_point < C_SUR_LO || o_out.code_point > C_SUR_HI))
        else $error("decoded value is not a scalar value");
`endif

endmodule

/* rtl/utf8d_front.sv */
module utf8d_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    utf8d_in_if.sink        i_in,
    input  logic            i_q_full,
    output logic            o_push,
    output utf8d_pkg::t_cmd o_cmd
);
    import utf8d_pkg::*;

    logic [1:0]      r_exp, n_exp;
    logic [1:0]      r_rcv, n_rcv;
    logic [CP_W-1:0] r_part, n_part;

    logic            w_accept;
    logic            w_open;
    logic            w_cont;
    logic [CP_W-1:0] w_val;
    logic [1:0]      w_rcv;
    logic            w_bad;
    logic [ERRS_W-1:0] w_flush;
    t_cmd            w_cmd;

    function automatic logic f_ctl(input logic [CP_W-1:0] cp);
        logic res;
        res = 1'b0;
        if (cp <= 21'h1F) begin
            res = (cp != 21'h09) && (cp != 21'h0A) && (cp != 21'h0D);
        end else if (cp == 21'h7F) begin
            res = 1'b1;
        end else if (cp >= 21'h80 && cp <= 21'h9F) begin
            res = 1'b1;
        end
        return res;
    endfunction

    assign i_in.ready = !i_q_full;
    assign w_accept   = i_in.valid && !i_q_full;
    assign w_open     = (r_exp != 2'd0);
    assign w_cont     = (i_in.text_byte[7:6] == 2'b10);
    assign w_val      = {r_part[CP_W-7:0], i_in.text_byte[5:0]};
    assign w_rcv      = r_rcv + 2'd1;
    assign w_flush    = w_open ? ({1'b0, r_rcv} + 3'd1) : 3'd0;

    always_comb begin
        w_bad = ((r_exp == 2'd1) && (w_val < C_MIN_TWO)) ||
                ((r_exp == 2'd2) && (w_val < C_MIN_THR)) ||
                ((r_exp == 2'd3) && (w_val < C_MIN_FOU)) ||
                (w_val > C_MAX_CP) ||
                ((w_val >= C_SUR_LO) && (w_val <= C_SUR_HI));
    end

    always_comb begin
        n_exp  = r_exp;
        n_rcv  = r_rcv;
        n_part = r_part;
        w_cmd  = '0;
        if (w_open && w_cont) begin
            if (w_rcv == r_exp) begin
                // Sequence complete: either the scalar value or one
                // replacement for every byte of the sequence.
                if (w_bad) begin
                    w_cmd.n_err = {1'b0, r_exp} + 3'd1;
                end else begin
                    w_cmd.tail_valid = 1'b1;
                    w_cmd.tail_cp    = w_val;
                    w_cmd.tail_width = {1'b0, r_exp} + 3'd1;
                    w_cmd.tail_ctl   = f_ctl(w_val);
                end
                n_exp  = 2'd0;
                n_rcv  = 2'd0;
                n_part = '0;
            end else if (i_in.end_of_text) begin
                w_cmd.n_err = {1'b0, w_rcv} + 3'd1;
                n_exp  = 2'd0;
                n_rcv  = 2'd0;
                n_part = '0;
            end else begin
                n_rcv  = w_rcv;
                n_part = w_val;
            end
        end else begin
            // Any open sequence is broken; the byte then starts afresh.
            w_cmd.n_err = w_flush;
            n_exp  = 2'd0;
            n_rcv  = 2'd0;
            n_part = '0;
            if (!i_in.text_byte[7]) begin
                w_cmd.tail_valid = 1'b1;
                w_cmd.tail_cp    = {13'd0, i_in.text_byte};
                w_cmd.tail_width = 3'd1;
                w_cmd.tail_ctl   = f_ctl({13'd0, i_in.text_byte});
            end else if (i_in.text_byte[7:5] == 3'b110 ||
                         i_in.text_byte[7:4] == 4'b1110 ||
                         i_in.text_byte[7:3] == 5'b11110) begin
                if (i_in.end_of_text) begin
                    w_cmd.n_err = w_flush + 3'd1;
                end else if (i_in.text_byte[7:5] == 3'b110) begin
                    n_exp  = 2'd1;
                    n_part = {16'd0, i_in.text_byte[4:0]};
                end else if (i_in.text_byte[7:4] == 4'b1110) begin
                    n_exp  = 2'd2;
                    n_part = {17'd0, i_in.text_byte[3:0]};
                end else begin
                    n_exp  = 2'd3;
                    n_part = {18'd0, i_in.text_byte[2:0]};
                end
            end else begin
                w_cmd.n_err = w_flush + 3'd1;
            end
        end
    end

    assign o_push = w_accept && ((w_cmd.n_err != 3'd0) || w_cmd.tail_valid);
    assign o_cmd  = w_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp  <= 2'd0;
            r_rcv  <= 2'd0;
            r_part <= '0;
        end else if (w_accept) begin
            r_exp  <= n_exp;
            r_rcv  <= n_rcv;
            r_part <= n_part;
        end
    end

endmodule

/* rtl/utf8d_queue.sv */
module utf8d_queue #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  utf8d_pkg::t_cmd i_cmd,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output utf8d_pkg::t_cmd o_cmd
);
    import utf8d_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          w_push, w_pop;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + PW'(1);
            end
            if (w_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + PW'(1);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

/* rtl/utf8d_back.sv */
module utf8d_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  utf8d_pkg::t_cmd i_cmd,
    output logic            o_pop,
    utf8d_out_if.source     o_out
);
    import utf8d_pkg::*;

    logic [1:0]         r_idx;
    logic               r_valid;
    logic [CP_W-1:0]    r_cp;
    logic [WIDTH_W-1:0] r_width;
    logic               r_err;
    logic               r_ctl;
    logic               r_last;

    logic [ERRS_W-1:0]  w_total;
    logic               w_is_err;
    logic               w_last;
    logic               w_load;

    assign w_total  = i_cmd.n_err + {2'd0, i_cmd.tail_valid};
    assign w_is_err = ({1'b0, r_idx} < i_cmd.n_err);
    assign w_last   = (({1'b0, r_idx} + 3'd1) == w_total);
    assign w_load   = i_valid && (!r_valid || o_out.ready);
    assign o_pop    = w_load && w_last;

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_cp    <= w_is_err ? C_REPL : i_cmd.tail_cp;
            r_width <= w_is_err ? 3'd1 : i_cmd.tail_width;
            r_err   <= w_is_err;
            r_ctl   <= w_is_err ? 1'b0 : i_cmd.tail_ctl;
            r_last  <= w_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_idx   <= w_last ? 2'd0 : r_idx + 2'd1;
                r_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.code_point  = r_cp;
    assign o_out.byte_count  = r_width;
    assign o_out.is_error    = r_err;
    assign o_out.is_control  = r_ctl;
    assign o_out.last_of_run = r_last;

endmodule

/* verif/utf8_stream_decoder_unit_checker.sv */
`timescale 1ns / 1ps

module utf8_stream_decoder_unit_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    utf8d_in_if  i_text,
    utf8d_out_if i_points,
    output int   o_fail_count,
    output int   o_pending_count,
    output int   o_checked_count,
    output int   o_repl_count
);
    import utf8d_pkg::*;

    localparam int PRINT_CAP = 40;

    localparam logic [CP_W-1:0] CP_TAB    = 21'h000009;
    localparam logic [CP_W-1:0] CP_LF     = 21'h00000A;
    localparam logic [CP_W-1:0] CP_CR     = 21'h00000D;
    localparam logic [CP_W-1:0] CP_C0_TOP = 21'h00001F;
    localparam logic [CP_W-1:0] CP_DEL    = 21'h00007F;
    localparam logic [CP_W-1:0] CP_C1_LO  = 21'h000080;
    localparam logic [CP_W-1:0] CP_C1_HI  = 21'h00009F;

    typedef struct packed {
        logic [CP_W-1:0]    cp;
        logic [WIDTH_W-1:0] width;
        logic               err;
        logic               ctl;
        logic               last;
    } t_scalar_word;

    // Open sequence: continuations expected, continuations taken, payload so far.
    logic [1:0]      seq_need;
    logic [1:0]      seq_got;
    logic [CP_W-1:0] seq_acc;

    t_scalar_word expected_words[$];
    int mismatch_total;
    int checked_total;
    int repl_total;

    function automatic logic is_control_point(input logic [CP_W-1:0] cp);
        if (cp <= CP_C0_TOP) return !(cp == CP_TAB || cp == CP_LF || cp == CP_CR);
        return (cp == CP_DEL) || (cp >= CP_C1_LO && cp <= CP_C1_HI);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_total < PRINT_CAP)
            $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
        mismatch_total++;
    endtask

    task automatic emit(input logic [CP_W-1:0] cp, input logic [WIDTH_W-1:0] width,
                        input logic err);
        t_scalar_word w;
        w.cp    = cp;
        w.width = width;
        w.err   = err;
        w.ctl   = !err && is_control_point(cp);
        w.last  = 1'b0;
        expected_words.push_back(w);
    endtask

    // Every byte already taken by the open sequence becomes one replacement.
    task automatic flush_open_sequence();
        int k;
        for (k = 0; k <= int'(seq_got); k++) emit(C_REPL, WIDTH_W'(1), 1'b1);
        seq_need = '0;
        seq_got  = '0;
        seq_acc  = '0;
    endtask

    task automatic predict_word(input logic [BYTE_W-1:0] b, input logic eot);
        int              start_size;
        logic [CP_W-1:0] v;
        t_scalar_word    tail;
        start_size = expected_words.size();
        if (seq_need != 0 && b[7:6] == 2'b10) begin
            seq_acc = (seq_acc << 6) | CP_W'(b[5:0]);
            seq_got = seq_got + 2'd1;
            if (seq_got == seq_need) begin
                v = seq_acc;
                if ((seq_need == 2'd1 && v < C_MIN_TWO) ||
                    (seq_need == 2'd2 && v < C_MIN_THR) ||
                    (seq_need == 2'd3 && v < C_MIN_FOU) ||
                    v > C_MAX_CP || (v >= C_SUR_LO && v <= C_SUR_HI)) begin
                    flush_open_sequence();
                end else begin
                    emit(v, WIDTH_W'(seq_need) + WIDTH_W'(1), 1'b0);
                    seq_need = '0;
                    seq_got  = '0;
                    seq_acc  = '0;
                end
            end
        end else begin
            // A non-continuation closes any open sequence and is then a new lead.
            if (seq_need != 0) flush_open_sequence();
            if (b[7] == 1'b0) begin
                emit(CP_W'(b), WIDTH_W'(1), 1'b0);
            end else if (b[7:5] == 3'b110) begin
                seq_need = 2'd1;
                seq_got  = '0;
                seq_acc  = CP_W'(b[4:0]);
            end else if (b[7:4] == 4'b1110) begin
                seq_need = 2'd2;
                seq_got  = '0;
                seq_acc  = CP_W'(b[3:0]);
            end else if (b[7:3] == 5'b11110) begin
                seq_need = 2'd3;
                seq_got  = '0;
                seq_acc  = CP_W'(b[2:0]);
            end else begin
                emit(C_REPL, WIDTH_W'(1), 1'b1);
            end
        end
        if (eot && seq_need != 0) flush_open_sequence();
        if (expected_words.size() > start_size) begin
            tail = expected_words.pop_back();
            tail.last = 1'b1;
            expected_words.push_back(tail);
        end
    endtask

    task automatic check_point_word();
        t_scalar_word want;
        if (expected_words.size() == 0) begin
            report_mismatch("unexpected result word", 32'(i_points.code_point), 32'h0);
            return;
        end
        want = expected_words.pop_front();
        checked_total++;
        if (i_points.is_error === 1'b1) repl_total++;
        if (i_points.code_point !== want.cp)
            report_mismatch("code_point", 32'(i_points.code_point), 32'(want.cp));
        if (i_points.byte_count !== want.width)
            report_mismatch("byte_count", 32'(i_points.byte_count), 32'(want.width));
        if (i_points.is_error !== want.err)
            report_mismatch("is_error", 32'(i_points.is_error), 32'(want.err));
        if (i_points.is_control !== want.ctl)
            report_mismatch("is_control", 32'(i_points.is_control), 32'(want.ctl));
        if (i_points.last_of_run !== want.last)
            report_mismatch("last_of_run", 32'(i_points.last_of_run), 32'(want.last));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            seq_need = '0;
            seq_got  = '0;
            seq_acc  = '0;
            expected_words.delete();
        end else begin
            if (i_points.valid === 1'b1 && i_points.ready === 1'b1) check_point_word();
            if (i_text.valid === 1'b1 && i_text.ready === 1'b1)
                predict_word(i_text.text_byte, i_text.end_of_text);
        end
        o_fail_count    <= mismatch_total;
        o_pending_count <= expected_words.size();
        o_checked_count <= checked_total;
        o_repl_count    <= repl_total;
    end

endmodule

/* verif/utf8_stream_decoder_unit_tb.sv */
`timescale 1ns / 1ps

module utf8_stream_decoder_unit_tb;
    import utf8d_pkg::*;

    // A stall of this many cycles with no word moving on either channel is a hang.
    localparam int STALL_LIMIT  = 1000;
    // Time given after the last predicted word for any surplus result word to show.
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_BYTES = 184;

    typedef struct packed {
        logic [BYTE_W-1:0] text_byte;
        logic              end_of_text;
    } t_text_word;

    // How the end of text flag is set on the bytes of one encoded sequence.
    typedef enum {EOT_NEVER, EOT_ON_LAST, EOT_RANDOM} t_eot_mode;

    logic i_clk = 1'b0;
    logic i_rst_n;

    utf8d_in_if  text_ch();
    utf8d_out_if point_ch();

    int fail_count;
    int pending_count;
    int checked_count;
    int repl_count;

    int send_idle_pct;
    int recv_idle_pct;
    int stall_cycles;
    int bytes_sent;
    int eot_sent;
    int directed_len;
    int total_len;
    int idx;
    int pick;
    int seq_len;

    // The whole byte stream is built before reset is released.
    t_text_word text_words[$];

    always #1 i_clk = ~i_clk;

    utf8_stream_decoder_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (text_ch),
        .o_out   (point_ch)
    );

    // The checker watches both channels, predicts every result word and counts failures.
    utf8_stream_decoder_unit_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_text          (text_ch),
        .i_points        (point_ch),
        .o_fail_count    (fail_count),
        .o_pending_count (pending_count),
        .o_checked_count (checked_count),
        .o_repl_count    (repl_count)
    );

    function automatic logic coin_eot();
        return $urandom_range(0, 99) < 4;
    endfunction

    task automatic push_word(input logic [BYTE_W-1:0] b, input logic eot);
        t_text_word w;
        w.text_byte   = b;
        w.end_of_text = eot;
        text_words.push_back(w);
    endtask

    // Encodes cp in len bytes, whether or not that length is the shortest one, and
    // keeps only the first keep bytes, so that a cut sequence is made the same way.
    task automatic push_encoded(input logic [CP_W-1:0] cp, input int len, input int keep,
                                input t_eot_mode mode);
        logic [BYTE_W-1:0] b;
        logic              eot;
        int                k;
        for (k = 0; k < keep; k++) begin
            if (k == 0) begin
                case (len)
                    1: begin
                        b = {1'b0, cp[6:0]};
                    end
                    2: begin
                        b = {3'b110, cp[10:6]};
                    end
                    3: begin
                        b = {4'b1110, cp[15:12]};
                    end
                    default: begin
                        b = {5'b11110, cp[20:18]};
                    end
                endcase
            end else begin
                b = {2'b10, 6'(cp >> (6 * (len - 1 - k)))};
            end
            case (mode)
                EOT_NEVER: begin
                    eot = 1'b0;
                end
                EOT_ON_LAST: begin
                    eot = (k == keep - 1);
                end
                default: begin
                    eot = coin_eot();
                end
            endcase
            push_word(b, eot);
        end
    endtask

    // The receiver drops ready at random, at the rate of the current phase.
    initial begin
        point_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            point_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // The watchdog restarts whenever a word moves on either channel.
    always @(posedge i_clk) begin
        if ((text_ch.valid === 1'b1 && text_ch.ready === 1'b1) ||
            (point_ch.valid === 1'b1 && point_ch.ready === 1'b1)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("utf8_stream_decoder_unit_tb: done, errors");
            $finish;
        end
    end

    initial begin
        text_ch.valid       <= 1'b0;
        text_ch.text_byte   <= '0;
        text_ch.end_of_text <= 1'b0;
        i_rst_n             <= 1'b0;
        send_idle_pct = 13;
        recv_idle_pct = 72;

        // Directed part. Control characters at both ends of the ASCII range, and a
        // line feed that ends the text while no sequence is open.
        push_word(8'h00, 1'b0);
        push_word(8'h7F, 1'b0);
        push_word(8'h0A, 1'b1);
        // The first C1 control and the highest scalar value.
        push_encoded(21'h000080, 2, 2, EOT_NEVER);
        push_encoded(21'h10FFFF, 4, 4, EOT_NEVER);
        // A surrogate, an overlong two-byte zero and a lead above F4 all complete
        // as sequences and then turn into one replacement per byte.
        push_encoded(21'h00D800, 3, 3, EOT_NEVER);
        push_encoded(21'h000000, 2, 2, EOT_NEVER);
        // A lone continuation byte and a byte that can never be a lead.
        push_word(8'h80, 1'b0);
        push_word(8'hFF, 1'b0);
        // A three-byte sequence broken by an ASCII letter, which is then decoded.
        push_encoded(21'h0020AC, 3, 2, EOT_NEVER);
        push_word(8'h41, 1'b0);
        // A four-byte sequence cut off by the end of the text.
        push_encoded(21'h010000, 4, 3, EOT_ON_LAST);
        push_encoded(21'h140000, 4, 4, EOT_NEVER);
        directed_len = text_words.size();

        // Random part. Most of it is well-formed sequences with random content; the
        // rest is cut sequences, wrong-length encodings and raw noise bytes.
        while (text_words.size() < directed_len + RANDOM_BYTES) begin
            pick = $urandom_range(0, 99);
            if (pick < 28) begin
                push_encoded(CP_W'($urandom_range(0, 21'h00007F)), 1, 1, EOT_RANDOM);
            end else if (pick < 48) begin
                push_encoded(CP_W'($urandom_range(21'h000080, 21'h0007FF)), 2, 2,
                             EOT_RANDOM);
            end else if (pick < 63) begin
                push_encoded(CP_W'($urandom_range(21'h000800, 21'h00FFFF)), 3, 3,
                             EOT_RANDOM);
            end else if (pick < 76) begin
                push_encoded(CP_W'($urandom_range(21'h010000, 21'h10FFFF)), 4, 4,
                             EOT_RANDOM);
            end else if (pick < 84) begin
                seq_len = $urandom_range(2, 4);
                push_encoded(CP_W'($urandom_range(21'h000080, 21'h10FFFF)), seq_len,
                             $urandom_range(1, seq_len - 1), EOT_RANDOM);
            end else if (pick < 90) begin
                // Values shifted down at random land often below the minimum of the
                // chosen length, which gives overlong forms.
                seq_len = $urandom_range(2, 4);
                push_encoded(CP_W'($urandom_range(0, 21'h1FFFFF) >> $urandom_range(0, 20)),
                             seq_len, seq_len, EOT_RANDOM);
            end else begin
                push_word(8'($urandom_range(0, 255)), coin_eot());
            end
        end
        total_len = text_words.size();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (idx = 0; idx < total_len; idx++) begin
            // Three phases: a mostly busy sender against a slow receiver, then the
            // reverse, then both at full rate.
            if (idx < total_len / 3) begin
                send_idle_pct = 13;
                recv_idle_pct = 72;
            end else if (idx < (2 * total_len) / 3) begin
                send_idle_pct = 72;
                recv_idle_pct = 13;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            while ($urandom_range(0, 99) < send_idle_pct) begin
                text_ch.valid <= 1'b0;
                @(posedge i_clk);
            end
            text_ch.valid       <= 1'b1;
            text_ch.text_byte   <= text_words[idx].text_byte;
            text_ch.end_of_text <= text_words[idx].end_of_text;
            @(posedge i_clk);
            while (text_ch.ready !== 1'b1) @(posedge i_clk);
            bytes_sent++;
            if (text_words[idx].end_of_text) eot_sent++;
        end
        text_ch.valid <= 1'b0;

        // Let every predicted word arrive, then give the block time to show extras.
        while (pending_count != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("summary: %0d text bytes sent (%0d directed), %0d flagged end of text",
                 bytes_sent, directed_len, eot_sent);
        $display("summary: %0d code point words checked, %0d of them replacements",
                 checked_count, repl_count);
        if (fail_count == 0 && pending_count == 0) begin
            $display("utf8_stream_decoder_unit_tb: done, clean");
        end else begin
            $display("utf8_stream_decoder_unit_tb: done, errors");
        end
        $finish;
    end

endmodule
